### design/lexk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lexk_pkg
// Types, key constant and mask helper functions for the XOR keystream block.
// ----------------------------------------------------------------------------
package lexk_pkg;

  localparam int unsigned HalfW  = 64;
  localparam int unsigned BlockW = 2 * HalfW;
  localparam int unsigned PadW   = 4;
  localparam int unsigned AmtW   = 7;

  // 16-byte key, byte 0 least significant
  localparam logic [HalfW-1:0] KeyLo = 64'h0065_616E_6153_654C;
  localparam logic [HalfW-1:0] KeyHi = 64'h7465_6579_3E01_55A4;
  localparam logic [BlockW-1:0] Key  = {KeyHi, KeyLo};

  typedef struct packed {
    logic [HalfW-1:0] data_high;
    logic [HalfW-1:0] data_low;
    logic             restart;
  } lexk_req_t;

  typedef struct packed {
    logic [HalfW-1:0] result_high;
    logic [HalfW-1:0] result_low;
  } lexk_rsp_t;

  function automatic logic [BlockW-1:0] rotl_key(input logic [AmtW-1:0] n);
    logic [2*BlockW-1:0] t;
    t = {Key, Key} << n;
    return t[2*BlockW-1:BlockW];
  endfunction

  // mask loaded on restart: key rotated left by (pad+1)*6
  function automatic logic [BlockW-1:0] init_mask(input logic [PadW-1:0] pad);
    logic [AmtW-1:0] p1;
    logic [AmtW-1:0] amt;
    p1  = AmtW'(pad) + AmtW'(1);
    amt = AmtW'(p1 * AmtW'(6));
    return rotl_key(amt);
  endfunction

  // increment: key rotated right by (pad+1)*7, i.e. left by 128 minus that
  function automatic logic [BlockW-1:0] incr(input logic [PadW-1:0] pad);
    logic [AmtW-1:0] p1;
    logic [AmtW-1:0] ramt;
    p1   = AmtW'(pad) + AmtW'(1);
    ramt = AmtW'(p1 * AmtW'(7));
    return rotl_key(AmtW'(0) - ramt);
  endfunction

  // byte add, then 16-bit lane subtract, then 32-bit lane add of the increment
  function automatic logic [HalfW-1:0] lane_update(input logic [HalfW-1:0] m,
                                                   input logic [HalfW-1:0] inc);
    logic [HalfW-1:0] a;
    logic [HalfW-1:0] b;
    logic [HalfW-1:0] c;
    for (int i = 0; i < HalfW / 8; i++) begin
      a[i*8 +: 8] = m[i*8 +: 8] + inc[i*8 +: 8];
    end
    for (int i = 0; i < HalfW / 16; i++) begin
      b[i*16 +: 16] = a[i*16 +: 16] - inc[i*16 +: 16];
    end
    for (int i = 0; i < HalfW / 32; i++) begin
      c[i*32 +: 32] = b[i*32 +: 32] + inc[i*32 +: 32];
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### design/lane_evolving_xor_keystream_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lane_evolving_xor_keystream_top
// 128-bit block XOR with a keystream mask that evolves by lane adds and subtracts per block.
// ----------------------------------------------------------------------------
// One request per cycle, one response per request, valid in the cycle after
// acceptance. The response sits in an output register; a new request is taken
// whenever that register is empty or being drained, so throughput is one block
// per clock. The mask update (byte add, 16-bit subtract, 32-bit add) is done in
// the same cycle the block is XORed. Restart mask and increment are recomputed
// into registers on each pad_count write; write pad_count only while idle.
module lane_evolving_xor_keystream_top (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [lexk_pkg::PadW-1:0]    cfg_wdata_i,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire lexk_pkg::lexk_req_t    in_req_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output lexk_pkg::lexk_rsp_t         out_rsp_o
);

  localparam int unsigned HalfW = lexk_pkg::HalfW;

  logic [lexk_pkg::BlockW-1:0] init_q, inc_q, mask_q, mask_d, mask_use;
  logic                        out_valid_q, out_valid_d;
  lexk_pkg::lexk_rsp_t         rsp_q, rsp_d;
  logic                        in_acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    mask_use = in_req_i.restart ? init_q : mask_q;
    rsp_d.result_low  = in_req_i.data_low  ^ mask_use[HalfW-1:0];
    rsp_d.result_high = in_req_i.data_high ^ mask_use[2*HalfW-1:HalfW];
    mask_d = mask_q;
    if (in_acc) begin
      mask_d = {lexk_pkg::lane_update(mask_use[2*HalfW-1:HalfW], inc_q[2*HalfW-1:HalfW]),
                lexk_pkg::lane_update(mask_use[HalfW-1:0], inc_q[HalfW-1:0])};
    end
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= lexk_pkg::init_mask('0);
      inc_q       <= lexk_pkg::incr('0);
      mask_q      <= lexk_pkg::init_mask('0);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        init_q <= lexk_pkg::init_mask(cfg_wdata_i);
        inc_q  <= lexk_pkg::incr(cfg_wdata_i);
      end
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

`ifndef SYNTH
  a_acc_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request did not produce a response");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while response stalled");

  a_restart_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.restart && !cfg_we_i |=>
      out_rsp_o.result_low == ($past(in_req_i.data_low) ^ init_q[HalfW-1:0]))
    else $error("restart block not XORed with initial mask");
`endif

endmodule
`default_nettype wire
